### hdl/sfnf_pkg.sv
// ----------------------------------------------------------------------------
// sfnf_pkg
// Shared types and constants for the structured field number formatter:
// item kinds, character select codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package sfnf_pkg;

	// Input value and magnitude width
	localparam int VALUE_W = 51;
	// Largest magnitude that may be printed
	localparam logic [VALUE_W-1:0] MAG_LIMIT = 51'd999999999999999;

	// BCD converter: 15 digits, 52-bit shift source, 4 bits per step
	localparam int NDIG          = 15;
	localparam int BCD_W         = NDIG * 4;
	localparam int BITS_PER_STEP = 4;
	localparam int SH_W          = 52;
	localparam int CONV_STEPS    = SH_W / BITS_PER_STEP;
	localparam int CNT_W         = $clog2(CONV_STEPS);
	localparam int DIG_IW        = $clog2(NDIG);

	// Decimal kind: three fraction digits
	localparam logic [DIG_IW-1:0] DEC_FLOOR = DIG_IW'(3);

	// ASCII characters
	localparam logic [7:0] CHR_AT    = 8'h40;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_QUEST = 8'h3F;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NUL   = 8'h00;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_INT  = 2'd0,
		KIND_DEC  = 2'd1,
		KIND_BOOL = 2'd2,
		KIND_DATE = 2'd3
	} kind_t;

	// Character source for the word being emitted
	typedef enum logic [2:0] {
		CH_AT    = 3'd0,
		CH_MINUS = 3'd1,
		CH_DIGIT = 3'd2,
		CH_DOT   = 3'd3,
		CH_QUEST = 3'd4,
		CH_BOOL  = 3'd5,
		CH_ERR   = 3'd6
	} char_sel_t;

	// Controller -> datapath
	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      scan;
		logic      dig_dec;
		logic      emit;
		char_sel_t sel;
		logic      last;
		logic      err;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  neg;
		logic  over;
		logic  bool_bad;
		logic  conv_done;
		logic  int_end;
		logic  frac_end;
	} sts_t;

	// One output word
	typedef struct packed {
		logic [7:0] chr;
		logic       last;
		logic       error;
	} out_word_t;

endpackage

### hdl/sfnf_dp.sv
// ----------------------------------------------------------------------------
// sfnf_dp
// Datapath: captures the item, takes the magnitude, converts it to BCD
// four bits per cycle, finds the leading digit and builds each output word.
// ----------------------------------------------------------------------------
module sfnf_dp
	import sfnf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic [1:0]                func,
	input  logic signed [VALUE_W-1:0] value,
	output sts_t                      sts,
	output out_word_t                 word
);

	kind_t              kind_q;
	logic               neg_q;
	logic [VALUE_W-1:0] mag_q;
	logic [SH_W-1:0]    sh_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIG_IW-1:0]  dig_q;
	logic [DIG_IW-1:0]  fend_q;

	logic [VALUE_W-1:0] mag_in;
	logic [SH_W-1:0]    sh_nx;
	logic [BCD_W-1:0]   bcd_nx;
	logic [DIG_IW-1:0]  floor_idx;
	logic [DIG_IW-1:0]  lead_nx;
	logic [DIG_IW-1:0]  fend_nx;
	logic [3:0]         cur_dig;
	logic [7:0]         chr;

	// Magnitude of the input; the most negative pattern yields 2^50
	assign mag_in = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

	// Double dabble, four source bits per step
	always_comb begin
		bcd_nx = bcd_q;
		sh_nx  = sh_q;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5)
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], sh_nx[SH_W-1]};
			sh_nx  = {sh_nx[SH_W-2:0], 1'b0};
		end
	end

	// Leading digit (never below the integer floor) and last fraction digit
	assign floor_idx = (kind_q == KIND_DEC) ? DEC_FLOOR : '0;

	always_comb begin
		lead_nx = floor_idx;
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0 && DIG_IW'(d) > floor_idx)
				lead_nx = DIG_IW'(d);
		end
	end

	always_comb begin
		if (bcd_q[3:0] != 4'd0)
			fend_nx = DIG_IW'(0);
		else if (bcd_q[7:4] != 4'd0)
			fend_nx = DIG_IW'(1);
		else
			fend_nx = DIG_IW'(2);
	end

	// Item and conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(func);
			neg_q  <= value[VALUE_W-1];
			mag_q  <= mag_in;
			sh_q   <= {1'b0, mag_in};
			bcd_q  <= '0;
		end else if (cmd.conv_step) begin
			sh_q  <= sh_nx;
			bcd_q <= bcd_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dig_q  <= '0;
			fend_q <= '0;
		end else begin
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.conv_step)
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.scan) begin
				dig_q  <= lead_nx;
				fend_q <= fend_nx;
			end else if (cmd.dig_dec) begin
				dig_q <= dig_q - DIG_IW'(1);
			end
		end
	end

	// Status to the controller
	assign sts.kind      = kind_q;
	assign sts.neg       = neg_q;
	assign sts.over      = mag_q > MAG_LIMIT;
	assign sts.bool_bad  = neg_q | (|mag_q[VALUE_W-1:1]);
	assign sts.conv_done = cnt_q == CNT_W'(CONV_STEPS - 1);
	assign sts.int_end   = dig_q == floor_idx;
	assign sts.frac_end  = dig_q == fend_q;

	// Character select
	assign cur_dig = bcd_q[{dig_q, 2'b00} +: 4];

	always_comb begin
		unique case (cmd.sel)
			CH_AT:    chr = CHR_AT;
			CH_MINUS: chr = CHR_MINUS;
			CH_DIGIT: chr = CHR_ZERO | {4'h0, cur_dig};
			CH_DOT:   chr = CHR_DOT;
			CH_QUEST: chr = CHR_QUEST;
			CH_BOOL:  chr = CHR_ZERO | {7'h00, mag_q[0]};
			CH_ERR:   chr = CHR_NUL;
			default:  chr = CHR_NUL;
		endcase
	end

	assign word.chr   = chr;
	assign word.last  = cmd.last;
	assign word.error = cmd.err;

endmodule

### hdl/sfnf_ctrl.sv
// ----------------------------------------------------------------------------
// sfnf_ctrl
// Controller: sequences check, conversion, scan and character emission.
// Emission states advance only when the output register can take a word.
// ----------------------------------------------------------------------------
module sfnf_ctrl
	import sfnf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	input  logic out_free,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_CHECK = 12'b0000_0000_0010,
		S_CONV  = 12'b0000_0000_0100,
		S_SCAN  = 12'b0000_0000_1000,
		S_AT    = 12'b0000_0001_0000,
		S_SIGN  = 12'b0000_0010_0000,
		S_INT   = 12'b0000_0100_0000,
		S_DOT   = 12'b0000_1000_0000,
		S_FRAC  = 12'b0001_0000_0000,
		S_BQ    = 12'b0010_0000_0000,
		S_BV    = 12'b0100_0000_0000,
		S_ERR   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   is_dec;

	assign is_dec   = sts.kind == KIND_DEC;
	assign in_ready = state_q == S_IDLE;

	// Next state and commands
	always_comb begin
		state_nx      = state_q;
		cmd           = '0;
		cmd.sel       = CH_ERR;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.kind == KIND_BOOL)
					state_nx = sts.bool_bad ? S_ERR : S_BQ;
				else
					state_nx = sts.over ? S_ERR : S_CONV;
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done)
					state_nx = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.kind == KIND_DATE)
					state_nx = S_AT;
				else if (sts.neg)
					state_nx = S_SIGN;
				else
					state_nx = S_INT;
			end
			S_AT: begin
				cmd.sel = CH_AT;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = sts.neg ? S_SIGN : S_INT;
				end
			end
			S_SIGN: begin
				cmd.sel = CH_MINUS;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_INT;
				end
			end
			S_INT: begin
				cmd.sel  = CH_DIGIT;
				cmd.last = sts.int_end & ~is_dec;
				if (out_free) begin
					cmd.emit    = 1'b1;
					cmd.dig_dec = 1'b1;
					if (sts.int_end)
						state_nx = is_dec ? S_DOT : S_IDLE;
				end
			end
			S_DOT: begin
				cmd.sel = CH_DOT;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_FRAC;
				end
			end
			S_FRAC: begin
				cmd.sel  = CH_DIGIT;
				cmd.last = sts.frac_end;
				if (out_free) begin
					cmd.emit    = 1'b1;
					cmd.dig_dec = 1'b1;
					if (sts.frac_end)
						state_nx = S_IDLE;
				end
			end
			S_BQ: begin
				cmd.sel = CH_QUEST;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_BV;
				end
			end
			S_BV: begin
				cmd.sel  = CH_BOOL;
				cmd.last = 1'b1;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			S_ERR: begin
				cmd.sel  = CH_ERR;
				cmd.last = 1'b1;
				cmd.err  = 1'b1;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

endmodule

### hdl/sfnf_oreg.sv
// ----------------------------------------------------------------------------
// sfnf_oreg
// Output register: holds one word until the consumer takes it, and tells
// the controller when a new word can be loaded.
// ----------------------------------------------------------------------------
module sfnf_oreg
	import sfnf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  out_word_t  word,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last,
	output logic       error
);

	logic      valid_q;
	out_word_t word_q;

	// Slot is free when empty or being drained this cycle
	assign free = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			word_q <= word;
	end

	assign out_valid = valid_q;
	assign out_char  = word_q.chr;
	assign last      = word_q.last;
	assign error     = word_q.error;

endmodule

### hdl/structured_field_number_formatter.sv
// ----------------------------------------------------------------------------
// structured_field_number_formatter
// Prints one numeric bare item (integer, decimal, boolean, date) as its
// canonical text, one ASCII character per output word.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   func[1:0], value[50:0] signed
//   output    out_valid / out_ready out_char[7:0], last, error
//
// Integer, decimal and date items pass acceptance, a range check, 13 BCD
// conversion steps (4 bits each) and a leading-digit scan, then emit one
// character per cycle unless the output stalls. Booleans emit two
// characters after the check, error items a single error word.
// Reset clears the controller and the output register valid bit.
// A stalled output holds the current character; the next item is accepted
// once the last character of the previous one sits in the output register.
// ----------------------------------------------------------------------------
module structured_field_number_formatter
	import sfnf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                func,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_char,
	output logic                      last,
	output logic                      error
);

	cmd_t      cmd;
	sts_t      sts;
	out_word_t word;
	logic      out_free;

	sfnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.out_free (out_free),
		.cmd      (cmd)
	);

	sfnf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.func   (func),
		.value  (value),
		.sts    (sts),
		.word   (word)
	);

	sfnf_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.emit),
		.word      (word),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last),
		.error     (error)
	);

	// An error word is always the single, final word of its item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && out_char == CHR_NUL)
		else $error("error word without last or with nonzero char");

	// Only one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// When idle, no unfinished item is left in the output register
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(out_valid && !last))
		else $error("idle while an item is incomplete");

endmodule

### tb/sv/sfnf_checker.sv
// ----------------------------------------------------------------------------
// sfnf_checker
// Watches both channels of the number formatter. Each accepted input word is
// turned into its expected character stream, and every accepted output word
// is compared field by field with the oldest expected character.
// ----------------------------------------------------------------------------
module sfnf_checker
	import sfnf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                func,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [7:0]                out_char,
	input  logic                      last,
	input  logic                      error,
	output int                        fail_count,
	output int                        chars_pending,
	output int                        items_taken,
	output int                        chars_checked,
	output int                        error_words
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	// Characters still owed by the block, oldest first
	out_word_t pending_chars[$];

	initial begin
		fail_count    = 0;
		chars_pending = 0;
		items_taken   = 0;
		chars_checked = 0;
		error_words   = 0;
	end

	// Append the canonical text of one number item to the pending queue
	function automatic void format_item(input kind_t kind, input logic [VALUE_W-1:0] raw);
		logic              neg;
		logic [VALUE_W-1:0] mag;
		longint unsigned   whole;
		string             digits;
		int                nfrac;
		byte               text[$];
		out_word_t         w;
		neg = raw[VALUE_W-1];
		mag = neg ? -raw : raw;
		// boolean: only 0 and 1 are legal
		if (kind == KIND_BOOL) begin
			if (neg || mag > 1) begin
				pending_chars.push_back('{chr: CHR_NUL, last: 1'b1, error: 1'b1});
				return;
			end
			text.push_back(CHR_QUEST);
			text.push_back(CHR_ZERO + mag[0]);
		end else if (mag > MAG_LIMIT) begin
			// too large to print at all
			pending_chars.push_back('{chr: CHR_NUL, last: 1'b1, error: 1'b1});
			return;
		end else begin
			if (kind == KIND_DATE)
				text.push_back(CHR_AT);
			if (neg)
				text.push_back(CHR_MINUS);
			if (kind == KIND_DEC) begin
				whole = 64'(mag) / 1000;
				digits = $sformatf("%0d", whole);
				foreach (digits[i])
					text.push_back(digits[i]);
				text.push_back(CHR_DOT);
				// three fraction digits, trailing zeros trimmed, at least one kept
				digits = $sformatf("%03d", 64'(mag) % 1000);
				nfrac = 3;
				while (nfrac > 1 && digits[nfrac-1] == CHR_ZERO)
					nfrac--;
				for (int i = 0; i < nfrac; i++)
					text.push_back(digits[i]);
			end else begin
				digits = $sformatf("%0d", mag);
				foreach (digits[i])
					text.push_back(digits[i]);
			end
		end
		foreach (text[i]) begin
			w.chr   = text[i];
			w.last  = (i == text.size() - 1);
			w.error = 1'b0;
			pending_chars.push_back(w);
		end
	endfunction

	// Predict on input acceptance, compare on output acceptance
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				format_item(kind_t'(func), value);
				items_taken <= items_taken + 1;
			end
			if (out_valid && out_ready) begin
				if (pending_chars.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: unexpected word char=%02h last=%b error=%b",
							$realtime, out_char, last, error);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_chars.pop_front();
					if (out_char !== want.chr || last !== want.last ||
							error !== want.error) begin
						if (fail_count < REPORT_MAX)
							$display("%0t: mismatch expected char=%02h last=%b error=%b, got char=%02h last=%b error=%b",
								$realtime, want.chr, want.last, want.error,
								out_char, last, error);
						fail_count <= fail_count + 1;
					end
					if (want.error)
						error_words <= error_words + 1;
				end
				chars_checked <= chars_checked + 1;
			end
			chars_pending <= pending_chars.size();
		end
	end

endmodule

### tb/sv/structured_field_number_formatter_tb.sv
// ----------------------------------------------------------------------------
// structured_field_number_formatter_tb
// Drives number items of all four kinds into the formatter: a directed set of
// range edges and special values, then random items of every digit count,
// with bursty input and a patterned output stall. Checking is done by
// sfnf_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module structured_field_number_formatter_tb
	import sfnf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                func;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [7:0]                out_char;
	logic                      last;
	logic                      error;

	int fail_count, chars_pending, items_taken, chars_checked, error_words;
	int cycles = 0;

	// Sender burst state
	int  burst_left = 1;
	bit  no_gaps = 1'b0;

	// Receiver stall pattern
	logic [15:0] ready_pat = 16'hFFFF;
	int          pat_age = 0;
	logic [3:0]  pat_bit = '0;

	always #6 clk = ~clk;

	structured_field_number_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.last     (last),
		.error    (error)
	);

	sfnf_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.last         (last),
		.error        (error),
		.fail_count   (fail_count),
		.chars_pending(chars_pending),
		.items_taken  (items_taken),
		.chars_checked(chars_checked),
		.error_words  (error_words)
	);

	// Output stall: rotate through a pattern, pick a new one now and then
	always @(negedge clk) begin
		if (pat_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pat <= 16'hFFFF;
				1: ready_pat <= 16'($urandom) | 16'h8000;
				2: ready_pat <= 16'($urandom & $urandom & $urandom) | 16'h0001;
				default: ready_pat <= 16'($urandom | $urandom) | 16'h0100;
			endcase
			pat_age <= $urandom_range(20, 200);
		end else begin
			pat_age <= pat_age - 1;
		end
		out_ready <= ready_pat[pat_bit];
		pat_bit <= pat_bit + 1'b1;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters outstanding",
				cycles, chars_pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Present one word at the current falling edge and hold it until taken
	task automatic send_item(input kind_t kind, input logic [VALUE_W-1:0] v);
		in_valid = 1'b1;
		func     = kind;
		value    = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 8);
			if (!no_gaps) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	endtask

	// Random value shaped for the given kind
	function automatic logic [VALUE_W-1:0] pick_value(input kind_t kind);
		longint unsigned   m;
		longint unsigned   span;
		int                ndig;
		logic [VALUE_W-1:0] v;
		if (kind == KIND_BOOL && $urandom_range(0, 4) != 0)
			return VALUE_W'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: return VALUE_W'({$urandom, $urandom});
			1: m = 64'(MAG_LIMIT) + $urandom_range(0, 4) - 2;
			2: m = $urandom_range(0, 2000);
			default: begin
				ndig = $urandom_range(1, 15);
				span = 1;
				repeat (ndig) span = span * 10;
				m = {$urandom, $urandom} % span;
			end
		endcase
		// decimals often land on whole tenths, hundredths or units
		if (kind == KIND_DEC && $urandom_range(0, 2) == 0) begin
			span = 1;
			repeat ($urandom_range(1, 3)) span = span * 10;
			m = m - m % span;
		end
		v = VALUE_W'(m);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	initial begin
		kind_t kind;
		in_valid = 1'b0;
		func     = KIND_INT;
		value    = '0;
		arst_n   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero, signs, range edges, fraction trimming, boolean rules
		send_item(KIND_INT, '0);
		send_item(KIND_INT, VALUE_W'(1));
		send_item(KIND_INT, -VALUE_W'(1));
		send_item(KIND_INT, MAG_LIMIT);
		send_item(KIND_INT, -MAG_LIMIT);
		send_item(KIND_INT, MAG_LIMIT + 1'b1);
		send_item(KIND_INT, -(MAG_LIMIT + 1'b1));
		send_item(KIND_INT, {1'b0, {(VALUE_W-1){1'b1}}});
		send_item(KIND_INT, {1'b1, {(VALUE_W-1){1'b0}}});
		send_item(KIND_DEC, '0);
		send_item(KIND_DEC, VALUE_W'(1000));
		send_item(KIND_DEC, VALUE_W'(1500));
		send_item(KIND_DEC, VALUE_W'(120));
		send_item(KIND_DEC, -VALUE_W'(1));
		send_item(KIND_DEC, VALUE_W'(123456));
		send_item(KIND_DEC, MAG_LIMIT);
		send_item(KIND_DEC, -(MAG_LIMIT + 1'b1));
		send_item(KIND_BOOL, '0);
		send_item(KIND_BOOL, VALUE_W'(1));
		send_item(KIND_BOOL, -VALUE_W'(1));
		send_item(KIND_BOOL, VALUE_W'(2));
		send_item(KIND_BOOL, {1'b0, {(VALUE_W-1){1'b1}}});
		send_item(KIND_DATE, '0);
		send_item(KIND_DATE, -MAG_LIMIT);
		send_item(KIND_DATE, MAG_LIMIT + 1'b1);

		// Random items; sender switches between gapped and back-to-back phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			kind = kind_t'($urandom_range(0, 3));
			send_item(kind, pick_value(kind));
		end
		in_valid = 1'b0;

		while (chars_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Formatted %0d number items of all four kinds into %0d checked words",
			items_taken, chars_checked);
		$display("of which %0d were error words; %0d cycles in all", error_words, cycles);
		if (chars_pending != 0)
			$display("%0d expected characters never arrived", chars_pending);
		if (fail_count == 0 && chars_pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
